@@ rtl/rvdec_pkg.sv @@
// ----------------------------------------------------------------------------
// rvdec_pkg
// Shared types and constants of the RV32IM instruction decoder: status codes,
// instruction formats, major opcodes, operation numbers and the result record.
// ----------------------------------------------------------------------------
package rvdec_pkg;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_BAD_OPCODE = 2'd1,
    ST_BAD_FUNCT  = 2'd2
  } rvdec_status_t;

  typedef enum logic [2:0] {
    FMT_R = 3'd0,
    FMT_I = 3'd1,
    FMT_S = 3'd2,
    FMT_B = 3'd3,
    FMT_U = 3'd4,
    FMT_J = 3'd5
  } rvdec_fmt_t;

  // Whole words that are matched before the opcode groups.
  localparam logic [31:0] WORD_ECALL = 32'h0000_0073;
  localparam logic [31:0] WORD_MRET  = 32'h3020_0073;

  // Major opcodes.
  localparam logic [6:0] OPC_OP     = 7'b0110011;
  localparam logic [6:0] OPC_LUI    = 7'b0110111;
  localparam logic [6:0] OPC_LOAD   = 7'b0000011;
  localparam logic [6:0] OPC_STORE  = 7'b0100011;
  localparam logic [6:0] OPC_OP_IMM = 7'b0010011;
  localparam logic [6:0] OPC_BRANCH = 7'b1100011;
  localparam logic [6:0] OPC_JALR   = 7'b1100111;
  localparam logic [6:0] OPC_AUIPC  = 7'b0010111;
  localparam logic [6:0] OPC_JAL    = 7'b1101111;
  localparam logic [6:0] OPC_SYSTEM = 7'b1110011;
  localparam logic [6:0] OPC_TRAP   = 7'b1101011;

  // funct7 values.
  localparam logic [6:0] F7_BASE = 7'b0000000;
  localparam logic [6:0] F7_ALT  = 7'b0100000;
  localparam logic [6:0] F7_MULDIV = 7'b0000001;

  // funct3 values.
  localparam logic [2:0] F3_0 = 3'd0;
  localparam logic [2:0] F3_1 = 3'd1;
  localparam logic [2:0] F3_2 = 3'd2;
  localparam logic [2:0] F3_3 = 3'd3;
  localparam logic [2:0] F3_4 = 3'd4;
  localparam logic [2:0] F3_5 = 3'd5;
  localparam logic [2:0] F3_6 = 3'd6;
  localparam logic [2:0] F3_7 = 3'd7;

  // Operation numbers.
  localparam logic [5:0] OP_ADD    = 6'd0;
  localparam logic [5:0] OP_SUB    = 6'd1;
  localparam logic [5:0] OP_XOR    = 6'd2;
  localparam logic [5:0] OP_OR     = 6'd3;
  localparam logic [5:0] OP_AND    = 6'd4;
  localparam logic [5:0] OP_SLL    = 6'd5;
  localparam logic [5:0] OP_SRL    = 6'd6;
  localparam logic [5:0] OP_SRA    = 6'd7;
  localparam logic [5:0] OP_SLT    = 6'd8;
  localparam logic [5:0] OP_SLTU   = 6'd9;
  localparam logic [5:0] OP_MUL    = 6'd10; // mul..remu follow in funct3 order
  localparam logic [5:0] OP_LUI    = 6'd18;
  localparam logic [5:0] OP_LB     = 6'd19;
  localparam logic [5:0] OP_LH     = 6'd20;
  localparam logic [5:0] OP_LW     = 6'd21;
  localparam logic [5:0] OP_LBU    = 6'd22;
  localparam logic [5:0] OP_LHU    = 6'd23;
  localparam logic [5:0] OP_SB     = 6'd24;
  localparam logic [5:0] OP_SH     = 6'd25;
  localparam logic [5:0] OP_SW     = 6'd26;
  localparam logic [5:0] OP_ADDI   = 6'd27;
  localparam logic [5:0] OP_XORI   = 6'd28;
  localparam logic [5:0] OP_ORI    = 6'd29;
  localparam logic [5:0] OP_ANDI   = 6'd30;
  localparam logic [5:0] OP_SLLI   = 6'd31;
  localparam logic [5:0] OP_SRLI   = 6'd32;
  localparam logic [5:0] OP_SRAI   = 6'd33;
  localparam logic [5:0] OP_SLTI   = 6'd34;
  localparam logic [5:0] OP_SLTI_U = 6'd35;
  localparam logic [5:0] OP_BEQ    = 6'd36;
  localparam logic [5:0] OP_BNE    = 6'd37;
  localparam logic [5:0] OP_BLT    = 6'd38;
  localparam logic [5:0] OP_BGE    = 6'd39;
  localparam logic [5:0] OP_BLTU   = 6'd40;
  localparam logic [5:0] OP_BGEU   = 6'd41;
  localparam logic [5:0] OP_JALR   = 6'd42;
  localparam logic [5:0] OP_PC_UPPER = 6'd43;
  localparam logic [5:0] OP_JAL    = 6'd44;
  localparam logic [5:0] OP_CSR_WRITE = 6'd45;
  localparam logic [5:0] OP_CSR_SET   = 6'd46;
  localparam logic [5:0] OP_CSR_CLEAR = 6'd47;
  localparam logic [5:0] OP_TRAP   = 6'd48;
  localparam logic [5:0] OP_ENV_CALL = 6'd49;
  localparam logic [5:0] OP_MRET   = 6'd50;

  typedef struct packed {
    rvdec_status_t      status;
    logic [5:0]         op_id;
    rvdec_fmt_t         format;
    logic [4:0]         rs1;
    logic [4:0]         rs2;
    logic [4:0]         rd;
    logic               reads_rs1;
    logic               reads_rs2;
    logic               rd_write;
    logic signed [31:0] imm_value;
  } rvdec_result_t;

endpackage

@@ rtl/rvdec_if.sv @@
// ----------------------------------------------------------------------------
// rvdec_if
// Valid/ready channels of the decoder: instruction words in, decode results
// out. A beat moves at a rising edge where valid and ready are both high.
// ----------------------------------------------------------------------------
interface rvdec_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] instr_word;

  modport source (output valid, output instr_word, input ready);
  modport sink   (input valid, input instr_word, output ready);
endinterface

interface rvdec_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic [5:0]         op_id;
  logic [2:0]         format;
  logic [4:0]         rs1;
  logic [4:0]         rs2;
  logic [4:0]         rd;
  logic               reads_rs1;
  logic               reads_rs2;
  logic               rd_write;
  logic signed [31:0] imm_value;

  modport source (
    output valid, output status, output op_id, output format, output rs1,
    output rs2, output rd, output reads_rs1, output reads_rs2, output rd_write,
    output imm_value, input ready
  );
  modport sink (
    input valid, input status, input op_id, input format, input rs1,
    input rs2, input rd, input reads_rs1, input reads_rs2, input rd_write,
    input imm_value, output ready
  );
endinterface

@@ rtl/rvdec_decode.sv @@
// ----------------------------------------------------------------------------
// rvdec_decode
// Combinational decode of one instruction word into the result record:
// operation lookup, format, register fields, flags and immediate.
// ----------------------------------------------------------------------------
module rvdec_decode
  import rvdec_pkg::*;
(
  input  logic [31:0]   instr_word,
  output rvdec_result_t result
);

  logic [6:0]    opcode;
  logic [2:0]    funct3;
  logic [6:0]    funct7;
  rvdec_status_t status;
  logic [5:0]    op_id;
  rvdec_fmt_t    fmt;
  logic [31:0]   imm;
  logic          is_r, is_i, is_s, is_b, is_u, is_j;

  assign opcode = instr_word[6:0];
  assign funct3 = instr_word[14:12];
  assign funct7 = instr_word[31:25];

  always_comb begin
    status = ST_OK;
    op_id  = OP_ADD;
    fmt    = FMT_R;
    if (instr_word == WORD_ECALL) begin
      op_id = OP_ENV_CALL;
      fmt   = FMT_I;
    end else if (instr_word == WORD_MRET) begin
      op_id = OP_MRET;
      fmt   = FMT_I;
    end else begin
      case (opcode)
        OPC_OP: begin
          fmt = FMT_R;
          if (funct7 == F7_MULDIV) begin
            op_id = OP_MUL + {3'b000, funct3};
          end else if (funct7 == F7_BASE) begin
            case (funct3)
              F3_0:    op_id = OP_ADD;
              F3_1:    op_id = OP_SLL;
              F3_2:    op_id = OP_SLT;
              F3_3:    op_id = OP_SLTU;
              F3_4:    op_id = OP_XOR;
              F3_5:    op_id = OP_SRL;
              F3_6:    op_id = OP_OR;
              default: op_id = OP_AND;
            endcase
          end else if (funct7 == F7_ALT && funct3 == F3_0) begin
            op_id = OP_SUB;
          end else if (funct7 == F7_ALT && funct3 == F3_5) begin
            op_id = OP_SRA;
          end else begin
            status = ST_BAD_FUNCT;
          end
        end
        OPC_LUI: begin
          fmt   = FMT_U;
          op_id = OP_LUI;
        end
        OPC_LOAD: begin
          fmt = FMT_I;
          case (funct3)
            F3_0:    op_id = OP_LB;
            F3_1:    op_id = OP_LH;
            F3_2:    op_id = OP_LW;
            F3_4:    op_id = OP_LBU;
            F3_5:    op_id = OP_LHU;
            default: status = ST_BAD_FUNCT;
          endcase
        end
        OPC_STORE: begin
          fmt = FMT_S;
          case (funct3)
            F3_0:    op_id = OP_SB;
            F3_1:    op_id = OP_SH;
            F3_2:    op_id = OP_SW;
            default: status = ST_BAD_FUNCT;
          endcase
        end
        OPC_OP_IMM: begin
          fmt = FMT_I;
          case (funct3)
            F3_0: op_id = OP_ADDI;
            F3_2: op_id = OP_SLTI;
            F3_3: op_id = OP_SLTI_U;
            F3_4: op_id = OP_XORI;
            F3_6: op_id = OP_ORI;
            F3_7: op_id = OP_ANDI;
            F3_1: begin
              if (funct7 == F7_BASE) op_id = OP_SLLI;
              else                   status = ST_BAD_FUNCT;
            end
            default: begin
              if (funct7 == F7_BASE)     op_id = OP_SRLI;
              else if (funct7 == F7_ALT) op_id = OP_SRAI;
              else                       status = ST_BAD_FUNCT;
            end
          endcase
        end
        OPC_BRANCH: begin
          fmt = FMT_B;
          case (funct3)
            F3_0:    op_id = OP_BEQ;
            F3_1:    op_id = OP_BNE;
            F3_4:    op_id = OP_BLT;
            F3_5:    op_id = OP_BGE;
            F3_6:    op_id = OP_BLTU;
            F3_7:    op_id = OP_BGEU;
            default: status = ST_BAD_FUNCT;
          endcase
        end
        OPC_JALR: begin
          fmt = FMT_I;
          if (funct3 == F3_0) op_id = OP_JALR;
          else                status = ST_BAD_FUNCT;
        end
        OPC_AUIPC: begin
          fmt   = FMT_U;
          op_id = OP_PC_UPPER;
        end
        OPC_JAL: begin
          fmt   = FMT_J;
          op_id = OP_JAL;
        end
        OPC_SYSTEM: begin
          // ecall and mret were caught above as whole words.
          fmt = FMT_I;
          case (funct3)
            F3_1:    op_id = OP_CSR_WRITE;
            F3_2:    op_id = OP_CSR_SET;
            F3_3:    op_id = OP_CSR_CLEAR;
            default: status = ST_BAD_FUNCT;
          endcase
        end
        OPC_TRAP: begin
          fmt   = FMT_U;
          op_id = OP_TRAP;
        end
        default: status = ST_BAD_OPCODE;
      endcase
    end
  end

  assign is_r = (fmt == FMT_R);
  assign is_i = (fmt == FMT_I);
  assign is_s = (fmt == FMT_S);
  assign is_b = (fmt == FMT_B);
  assign is_u = (fmt == FMT_U);
  assign is_j = (fmt == FMT_J);

  always_comb begin
    case (fmt)
      FMT_I: imm = {{20{instr_word[31]}}, instr_word[31:20]};
      FMT_S: imm = {{20{instr_word[31]}}, instr_word[31:25], instr_word[11:7]};
      FMT_B: imm = {{19{instr_word[31]}}, instr_word[31], instr_word[7],
                    instr_word[30:25], instr_word[11:8], 1'b0};
      FMT_U: imm = {instr_word[31:12], 12'h000};
      FMT_J: imm = {{11{instr_word[31]}}, instr_word[31], instr_word[19:12],
                    instr_word[20], instr_word[30:21], 1'b0};
      default: imm = 32'h0000_0000;
    endcase
  end

  // A failed decode reports only its status; every other field is zero.
  always_comb begin
    if (status != ST_OK) begin
      result        = '0;
      result.status = status;
    end else begin
      result.status    = ST_OK;
      result.op_id     = op_id;
      result.format    = fmt;
      result.rs1       = instr_word[19:15];
      result.rs2       = instr_word[24:20];
      result.rd        = instr_word[11:7];
      result.reads_rs1 = is_r | is_i | is_s | is_b;
      result.reads_rs2 = is_r | is_s | is_b;
      result.rd_write  = (is_r | is_i | is_u | is_j) && (instr_word[11:7] != 5'd0);
      result.imm_value = imm;
    end
  end

endmodule

@@ rtl/rv32im_instruction_decoder_top.sv @@
// ----------------------------------------------------------------------------
// rv32im_instruction_decoder_top
// RV32IM instruction decoder with an input register and a result register.
// ----------------------------------------------------------------------------
// Usage:
//   in_chan carries one 32-bit instruction word per beat; out_chan returns
//   one decode result per word, in order: status, operation number, format,
//   register fields, read/write flags and the sign-extended immediate.
//   A word is captured in the input register, decoded by one level of
//   combinational logic and captured in the result register once that
//   register is free. The decoder sustains one word per cycle while the
//   receiver does not stall; the single decode pass between the two
//   registers sets that rate.
//   When the receiver stalls, the result register holds its beat and one
//   more word can still be taken into the input register; after that
//   in_chan.ready drops until out_chan.ready returns.
//   The synchronous active-low reset empties both registers; no result is
//   shown until a new word arrives.
// ----------------------------------------------------------------------------
module rv32im_instruction_decoder_top
  import rvdec_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  rvdec_in_if.sink   in_chan,
  rvdec_out_if.source out_chan
);

  logic          in_valid_r;
  logic          in_valid_nxt;
  logic [31:0]   instr_r;
  logic          out_valid_r;
  logic          out_valid_nxt;
  rvdec_result_t result_r;
  rvdec_result_t dec_result;
  logic          out_free;
  logic          in_take;
  logic          advance;

  assign out_free = !out_valid_r || out_chan.ready;
  assign advance  = in_valid_r && out_free;
  assign in_chan.ready = !in_valid_r || out_free;
  assign in_take  = in_chan.valid && in_chan.ready;

  rvdec_decode u_decode (
    .instr_word (instr_r),
    .result     (dec_result)
  );

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_take)      in_valid_nxt = 1'b1;
    else if (advance) in_valid_nxt = 1'b0;
    out_valid_nxt = out_valid_r;
    if (advance)       out_valid_nxt = 1'b1;
    else if (out_free) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      instr_r <= in_chan.instr_word;
    end
    if (advance) begin
      result_r <= dec_result;
    end
  end

  assign out_chan.valid     = out_valid_r;
  assign out_chan.status    = result_r.status;
  assign out_chan.op_id     = result_r.op_id;
  assign out_chan.format    = result_r.format;
  assign out_chan.rs1       = result_r.rs1;
  assign out_chan.rs2       = result_r.rs2;
  assign out_chan.rd        = result_r.rd;
  assign out_chan.reads_rs1 = result_r.reads_rs1;
  assign out_chan.reads_rs2 = result_r.reads_rs2;
  assign out_chan.rd_write  = result_r.rd_write;
  assign out_chan.imm_value = result_r.imm_value;

  // A word waiting in the input register moves on whenever the result slot is empty.
  a_stage_moves: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid_r && !out_valid_r) |=> out_valid_r)
    else $error("decoded word was not moved into the result register");

  // A failed decode carries no operation, flags or immediate.
  a_fail_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && result_r.status != ST_OK) |->
      (result_r.op_id == 6'd0 && result_r.imm_value == 32'sd0 &&
       !result_r.rd_write && !result_r.reads_rs1))
    else $error("failed decode carries nonzero fields");

  // x0 is never marked as written.
  a_no_x0_write: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && result_r.rd_write) |-> (result_r.rd != 5'd0))
    else $error("rd_write set for destination x0");

  // Every format that reads rs2 also reads rs1.
  a_rs_flags: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && result_r.reads_rs2) |-> result_r.reads_rs1)
    else $error("reads_rs2 without reads_rs1");

endmodule

@@ dv/testbench.sv @@
// ----------------------------------------------------------------------------
// RV32IM instruction decoder testbench
// Sends instruction words through the valid/ready input channel and checks
// every decode result, in order, against a behavioral decoder kept in this
// file. Special words, every operation, back pressure and random streams with
// idle gaps on both sides are covered.
// ----------------------------------------------------------------------------
module testbench
  import rvdec_pkg::*;
;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned DRAIN_CYCLES = 8;

  logic clk;
  logic rst_n;

  rvdec_in_if  in_chan ();
  rvdec_out_if out_chan ();

  rv32im_instruction_decoder_top dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  rvdec_result_t expected_decodes [$];
  int unsigned   error_count  = 0;
  int unsigned   cycle_count  = 0;
  int unsigned   hold_request = 0;
  bit            sender_gaps  = 1'b0;
  bit            sink_stalls  = 1'b0;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Behavioral decoder: what the block should report for one word.
  function automatic rvdec_result_t decode_word(input logic [31:0] w);
    rvdec_result_t r;
    rvdec_status_t st;
    rvdec_fmt_t    fmt;
    logic [5:0]    op;
    logic [6:0]    opc;
    logic [6:0]    f7;
    logic [2:0]    f3;
    opc = w[6:0];
    f3  = w[14:12];
    f7  = w[31:25];
    st  = ST_OK;
    fmt = FMT_R;
    op  = '0;
    r   = '0;
    if (w == WORD_ECALL) begin
      op = OP_ENV_CALL;
      fmt = FMT_I;
    end else if (w == WORD_MRET) begin
      op = OP_MRET;
      fmt = FMT_I;
    end else begin
      case (opc)
        OPC_OP: begin
          fmt = FMT_R;
          case (f7)
            F7_BASE: begin
              case (f3)
                F3_0: op = OP_ADD;
                F3_1: op = OP_SLL;
                F3_2: op = OP_SLT;
                F3_3: op = OP_SLTU;
                F3_4: op = OP_XOR;
                F3_5: op = OP_SRL;
                F3_6: op = OP_OR;
                default: op = OP_AND;
              endcase
            end
            F7_ALT: begin
              if (f3 == F3_0) op = OP_SUB;
              else if (f3 == F3_5) op = OP_SRA;
              else st = ST_BAD_FUNCT;
            end
            F7_MULDIV: op = OP_MUL + {3'b000, f3};
            default: st = ST_BAD_FUNCT;
          endcase
        end
        OPC_LUI: begin
          fmt = FMT_U;
          op = OP_LUI;
        end
        OPC_LOAD: begin
          fmt = FMT_I;
          case (f3)
            F3_0: op = OP_LB;
            F3_1: op = OP_LH;
            F3_2: op = OP_LW;
            F3_4: op = OP_LBU;
            F3_5: op = OP_LHU;
            default: st = ST_BAD_FUNCT;
          endcase
        end
        OPC_STORE: begin
          fmt = FMT_S;
          case (f3)
            F3_0: op = OP_SB;
            F3_1: op = OP_SH;
            F3_2: op = OP_SW;
            default: st = ST_BAD_FUNCT;
          endcase
        end
        OPC_OP_IMM: begin
          fmt = FMT_I;
          case (f3)
            F3_0: op = OP_ADDI;
            F3_2: op = OP_SLTI;
            F3_3: op = OP_SLTI_U;
            F3_4: op = OP_XORI;
            F3_6: op = OP_ORI;
            F3_7: op = OP_ANDI;
            F3_1: begin
              if (f7 == F7_BASE) op = OP_SLLI;
              else st = ST_BAD_FUNCT;
            end
            default: begin
              if (f7 == F7_BASE) op = OP_SRLI;
              else if (f7 == F7_ALT) op = OP_SRAI;
              else st = ST_BAD_FUNCT;
            end
          endcase
        end
        OPC_BRANCH: begin
          fmt = FMT_B;
          case (f3)
            F3_0: op = OP_BEQ;
            F3_1: op = OP_BNE;
            F3_4: op = OP_BLT;
            F3_5: op = OP_BGE;
            F3_6: op = OP_BLTU;
            F3_7: op = OP_BGEU;
            default: st = ST_BAD_FUNCT;
          endcase
        end
        OPC_JALR: begin
          fmt = FMT_I;
          if (f3 == F3_0) op = OP_JALR;
          else st = ST_BAD_FUNCT;
        end
        OPC_AUIPC: begin
          fmt = FMT_U;
          op = OP_PC_UPPER;
        end
        OPC_JAL: begin
          fmt = FMT_J;
          op = OP_JAL;
        end
        OPC_SYSTEM: begin
          fmt = FMT_I;
          case (f3)
            F3_1: op = OP_CSR_WRITE;
            F3_2: op = OP_CSR_SET;
            F3_3: op = OP_CSR_CLEAR;
            default: st = ST_BAD_FUNCT;
          endcase
        end
        OPC_TRAP: begin
          fmt = FMT_U;
          op = OP_TRAP;
        end
        default: st = ST_BAD_OPCODE;
      endcase
    end

    // A failed decode reports nothing but its status.
    if (st != ST_OK) begin
      r.status = st;
      return r;
    end

    r.status    = ST_OK;
    r.op_id     = op;
    r.format    = fmt;
    r.rs1       = w[19:15];
    r.rs2       = w[24:20];
    r.rd        = w[11:7];
    r.reads_rs1 = (fmt == FMT_R) || (fmt == FMT_I) || (fmt == FMT_S) || (fmt == FMT_B);
    r.reads_rs2 = (fmt == FMT_R) || (fmt == FMT_S) || (fmt == FMT_B);
    r.rd_write  = ((fmt == FMT_R) || (fmt == FMT_I) || (fmt == FMT_U) || (fmt == FMT_J))
                  && (w[11:7] != 5'd0);
    case (fmt)
      FMT_I: r.imm_value = {{20{w[31]}}, w[31:20]};
      FMT_S: r.imm_value = {{20{w[31]}}, w[31:25], w[11:7]};
      FMT_B: r.imm_value = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
      FMT_U: r.imm_value = {w[31:12], 12'd0};
      FMT_J: r.imm_value = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
      default: r.imm_value = '0;
    endcase
    return r;
  endfunction

  // Imposes the opcode and function fields of one operation on a raw word.
  function automatic logic [31:0] shape_word(input logic [5:0] op, input logic [31:0] raw);
    logic [6:0]  opc;
    logic [6:0]  f7;
    logic [2:0]  f3;
    logic [31:0] w;
    f3 = F3_0;
    f7 = F7_BASE;
    case (op)
      OP_ADD:   opc = OPC_OP;
      OP_SUB:   begin opc = OPC_OP; f7 = F7_ALT; end
      OP_XOR:   begin opc = OPC_OP; f3 = F3_4; end
      OP_OR:    begin opc = OPC_OP; f3 = F3_6; end
      OP_AND:   begin opc = OPC_OP; f3 = F3_7; end
      OP_SLL:   begin opc = OPC_OP; f3 = F3_1; end
      OP_SRL:   begin opc = OPC_OP; f3 = F3_5; end
      OP_SRA:   begin opc = OPC_OP; f3 = F3_5; f7 = F7_ALT; end
      OP_SLT:   begin opc = OPC_OP; f3 = F3_2; end
      OP_SLTU:  begin opc = OPC_OP; f3 = F3_3; end
      OP_LUI:   opc = OPC_LUI;
      OP_LB:    opc = OPC_LOAD;
      OP_LH:    begin opc = OPC_LOAD; f3 = F3_1; end
      OP_LW:    begin opc = OPC_LOAD; f3 = F3_2; end
      OP_LBU:   begin opc = OPC_LOAD; f3 = F3_4; end
      OP_LHU:   begin opc = OPC_LOAD; f3 = F3_5; end
      OP_SB:    opc = OPC_STORE;
      OP_SH:    begin opc = OPC_STORE; f3 = F3_1; end
      OP_SW:    begin opc = OPC_STORE; f3 = F3_2; end
      OP_ADDI:  opc = OPC_OP_IMM;
      OP_XORI:  begin opc = OPC_OP_IMM; f3 = F3_4; end
      OP_ORI:   begin opc = OPC_OP_IMM; f3 = F3_6; end
      OP_ANDI:  begin opc = OPC_OP_IMM; f3 = F3_7; end
      OP_SLLI:  begin opc = OPC_OP_IMM; f3 = F3_1; end
      OP_SRLI:  begin opc = OPC_OP_IMM; f3 = F3_5; end
      OP_SRAI:  begin opc = OPC_OP_IMM; f3 = F3_5; f7 = F7_ALT; end
      OP_SLTI:  begin opc = OPC_OP_IMM; f3 = F3_2; end
      OP_SLTI_U: begin opc = OPC_OP_IMM; f3 = F3_3; end
      OP_BEQ:   opc = OPC_BRANCH;
      OP_BNE:   begin opc = OPC_BRANCH; f3 = F3_1; end
      OP_BLT:   begin opc = OPC_BRANCH; f3 = F3_4; end
      OP_BGE:   begin opc = OPC_BRANCH; f3 = F3_5; end
      OP_BLTU:  begin opc = OPC_BRANCH; f3 = F3_6; end
      OP_BGEU:  begin opc = OPC_BRANCH; f3 = F3_7; end
      OP_JALR:  opc = OPC_JALR;
      OP_PC_UPPER: opc = OPC_AUIPC;
      OP_JAL:   opc = OPC_JAL;
      OP_CSR_WRITE: begin opc = OPC_SYSTEM; f3 = F3_1; end
      OP_CSR_SET:   begin opc = OPC_SYSTEM; f3 = F3_2; end
      OP_CSR_CLEAR: begin opc = OPC_SYSTEM; f3 = F3_3; end
      OP_TRAP:  opc = OPC_TRAP;
      OP_ENV_CALL: return WORD_ECALL;
      OP_MRET:  return WORD_MRET;
      // The multiply and divide group follows funct3 order from mul.
      default:  begin opc = OPC_OP; f7 = F7_MULDIV; f3 = op[2:0] + 3'd6; end
    endcase
    w = raw;
    w[6:0] = opc;
    if (opc != OPC_LUI && opc != OPC_AUIPC && opc != OPC_JAL && opc != OPC_TRAP)
      w[14:12] = f3;
    if (opc == OPC_OP || (opc == OPC_OP_IMM && (f3 == F3_1 || f3 == F3_5)))
      w[31:25] = f7;
    return w;
  endfunction

  // Mostly well-formed words with random content; the rest is noise.
  function automatic logic [31:0] random_word();
    int unsigned roll;
    logic [31:0] w;
    roll = $urandom_range(0, 99);
    w = $urandom();
    if (roll < 65) begin
      w = shape_word(6'($urandom_range(0, 50)), w);
    end else if (roll < 75) begin
      w = shape_word(6'($urandom_range(0, 50)), w);
      w[$urandom_range(0, 31)] ^= 1'b1;
    end else if (roll < 90) begin
      case ($urandom_range(0, 10))
        0: w[6:0] = OPC_OP;
        1: w[6:0] = OPC_LUI;
        2: w[6:0] = OPC_LOAD;
        3: w[6:0] = OPC_STORE;
        4: w[6:0] = OPC_OP_IMM;
        5: w[6:0] = OPC_BRANCH;
        6: w[6:0] = OPC_JALR;
        7: w[6:0] = OPC_AUIPC;
        8: w[6:0] = OPC_JAL;
        9: w[6:0] = OPC_SYSTEM;
        default: w[6:0] = OPC_TRAP;
      endcase
    end
    return w;
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned pick_idle();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  task automatic send_word(input logic [31:0] w);
    int unsigned gap;
    in_chan.valid      <= 1'b1;
    in_chan.instr_word <= w;
    do @(posedge clk); while (in_chan.ready !== 1'b1);
    expected_decodes.push_back(decode_word(w));
    gap = sender_gaps ? pick_idle() : 0;
    if (gap != 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Drops valid and waits on the clock, so the next beat starts cleanly.
  task automatic stop_offering();
    in_chan.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_for_results();
    while (expected_decodes.size() != 0) @(posedge clk);
  endtask

  task automatic test_special_words();
    logic [31:0] words [$];
    words = '{
      32'h0000_0073, 32'h3020_0073, 32'h0010_0073, 32'h3020_00F3,
      32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0033, 32'h01FF_8FB3,
      32'hFE00_0033, 32'h0200_7033, 32'h41F0_D093, 32'h4000_1093,
      32'hFFF0_0093, 32'h7FF0_0093, 32'h8000_2083, 32'h0000_3003,
      32'hFE11_2FA3, 32'h0000_3023, 32'h8000_0063, 32'h7E00_1FE3,
      32'h0000_2063, 32'h0000_1067, 32'hFFFF_F0B7, 32'h8000_006F,
      32'h7FFF_F0EF, 32'h0000_006B, 32'h3000_1073
    };
    sender_gaps = 1'b1;
    sink_stalls = 1'b1;
    foreach (words[i]) send_word(words[i]);
    stop_offering();
  endtask

  task automatic test_each_operation();
    sender_gaps = 1'b0;
    sink_stalls = 1'b0;
    for (int op = 0; op <= 50; op++) send_word(shape_word(6'(op), $urandom()));
    stop_offering();
  endtask

  // The receiver holds off long enough for the block to fill up and stall
  // its input while words keep coming.
  task automatic test_back_pressure();
    sender_gaps = 1'b0;
    sink_stalls = 1'b0;
    hold_request = 150;
    repeat (24) send_word(random_word());
    stop_offering();
  endtask

  task automatic test_drain_pause();
    sender_gaps = 1'b1;
    sink_stalls = 1'b1;
    repeat (3) begin
      repeat (10) send_word(random_word());
      stop_offering();
      wait_for_results();
    end
  endtask

  task automatic test_random_stream();
    for (int seg = 0; seg < 7; seg++) begin
      sender_gaps = (seg % 4 == 0) || (seg % 4 == 2);
      sink_stalls = (seg % 4 == 0) || (seg % 4 == 3);
      repeat (100) send_word(random_word());
    end
    stop_offering();
  endtask

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk) begin : result_check
    rvdec_result_t want;
    if (rst_n === 1'b1 && out_chan.valid === 1'b1 && out_chan.ready === 1'b1) begin
      if (expected_decodes.size() == 0) begin
        $error("result beat with no word outstanding");
        error_count++;
      end else begin
        want = expected_decodes.pop_front();
        compare_field("status",    32'(want.status),    32'(out_chan.status));
        compare_field("op_id",     32'(want.op_id),     32'(out_chan.op_id));
        compare_field("format",    32'(want.format),    32'(out_chan.format));
        compare_field("rs1",       32'(want.rs1),       32'(out_chan.rs1));
        compare_field("rs2",       32'(want.rs2),       32'(out_chan.rs2));
        compare_field("rd",        32'(want.rd),        32'(out_chan.rd));
        compare_field("reads_rs1", 32'(want.reads_rs1), 32'(out_chan.reads_rs1));
        compare_field("reads_rs2", 32'(want.reads_rs2), 32'(out_chan.reads_rs2));
        compare_field("rd_write",  32'(want.rd_write),  32'(out_chan.rd_write));
        compare_field("imm_value", 32'(want.imm_value), 32'(out_chan.imm_value));
      end
    end
  end

  // Receiver: random stalls, or one long hold when a test asks for it.
  initial begin : result_receiver
    int unsigned stall;
    out_chan.ready <= 1'b0;
    forever begin
      @(posedge clk);
      stall = 0;
      if (hold_request != 0) begin
        stall = hold_request;
        hold_request = 0;
      end else if (sink_stalls && $urandom_range(0, 2) == 0) begin
        stall = pick_idle();
      end
      if (stall != 0) begin
        out_chan.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_chan.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : watchdog
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  initial begin : test_sequence
    rst_n              <= 1'b0;
    in_chan.valid      <= 1'b0;
    in_chan.instr_word <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_special_words();
    test_each_operation();
    test_back_pressure();
    test_drain_pause();
    test_random_stream();

    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/rvdec_pkg.sv
rtl/rvdec_if.sv
rtl/rvdec_decode.sv
rtl/rv32im_instruction_decoder_top.sv
dv/testbench.sv
